@@ hw/rtl/ghc_pkg.sv @@
// Shared types and constants for the gear hash chunker.
// No dependencies; used by every module of the block.
package ghc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned MASK_W = 5;
    localparam int unsigned TABLE_DEPTH = 256;

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_TABLE = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [MASK_W-1:0] MASK_BITS_RESET = 5'd13;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] byte_value;
        logic [BYTE_W-1:0] table_index;
        logic [WORD_W-1:0] table_word;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] chunk_length;
        logic              at_end;
    } t_out_word;

    typedef struct packed {
        logic       valid;
        logic [1:0] opcode;
    } t_stage_ctl;

endpackage

@@ hw/rtl/ghc_gear_mem.sv @@
// Gear table storage: 256 words, one write port and one registered read port.
// Depends on ghc_pkg for widths.
module ghc_gear_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [ghc_pkg::BYTE_W-1:0]    i_waddr,
    input  logic [ghc_pkg::WORD_W-1:0]    i_wdata,
    input  logic                          i_re,
    input  logic [ghc_pkg::BYTE_W-1:0]    i_raddr,
    output logic [ghc_pkg::WORD_W-1:0]    o_rdata
);

    logic [ghc_pkg::WORD_W-1:0] r_mem [ghc_pkg::TABLE_DEPTH];
    logic [ghc_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ghc_chunk_core.sv @@
// Fingerprint update, boundary test, length counter and result register.
// Depends on ghc_pkg for types and opcodes.
module ghc_chunk_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ghc_pkg::t_stage_ctl           i_ctl,
    input  logic [ghc_pkg::WORD_W-1:0]    i_gear_word,
    input  logic [ghc_pkg::MASK_W-1:0]    i_mask_bits,
    output logic                          o_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ghc_pkg::t_out_word            o_out_word
);

    logic [ghc_pkg::WORD_W-1:0] r_fingerprint;
    logic [ghc_pkg::WORD_W-1:0] r_byte_count;
    logic                       r_out_valid;
    ghc_pkg::t_out_word         r_out_word;

    logic [ghc_pkg::WORD_W-1:0] n_fingerprint;
    logic [ghc_pkg::WORD_W-1:0] n_byte_count;
    logic [ghc_pkg::WORD_W-1:0] hash_next;
    logic [ghc_pkg::WORD_W-1:0] count_next;
    logic [ghc_pkg::WORD_W-1:0] low_mask;
    logic                       fire;
    logic                       emit;
    ghc_pkg::t_out_word         n_out_word;

    assign o_ready = !r_out_valid || i_out_ready;
    assign fire    = i_ctl.valid && o_ready;

    assign hash_next  = {r_fingerprint[ghc_pkg::WORD_W-2:0], 1'b0} + i_gear_word;
    assign count_next = (r_byte_count == '1) ? r_byte_count : r_byte_count + 1'b1;
    assign low_mask   = ~({ghc_pkg::WORD_W{1'b1}} << i_mask_bits);

    always_comb begin
        n_fingerprint           = r_fingerprint;
        n_byte_count            = r_byte_count;
        emit                    = 1'b0;
        n_out_word.chunk_length = count_next;
        n_out_word.at_end       = 1'b0;
        case (i_ctl.opcode)
            ghc_pkg::OP_DATA: begin
                n_fingerprint = hash_next;
                n_byte_count  = count_next;
                if ((hash_next & low_mask) == '0) begin
                    emit          = 1'b1;
                    n_fingerprint = '1;
                    n_byte_count  = '0;
                end
            end
            ghc_pkg::OP_END: begin
                n_out_word.chunk_length = r_byte_count;
                n_out_word.at_end       = 1'b1;
                if (r_byte_count != '0) begin
                    emit          = 1'b1;
                    n_fingerprint = '1;
                    n_byte_count  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fingerprint <= '1;
            r_byte_count  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_fingerprint <= n_fingerprint;
                r_byte_count  <= n_byte_count;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ hw/rtl/gear_hash_chunker_unit.sv @@
// Top level of the gear hash chunker: input stage, gear table and hash core.
// Depends on ghc_pkg, ghc_gear_mem and ghc_chunk_core.
//
// The unit accepts one word per clock unless the output stalls, and returns a
// chunk length for the data or end-of-stream word that closes the chunk. The
// gear table read port registers the entry for the byte; the core adds it to
// the shifted fingerprint, tests the low mask_bits bits and loads the result
// register, and that single-register fingerprint loop sets the rate of one
// byte per clock. The gear table has no reset value and must be loaded with
// all 256 entries before any data word arrives. mask_bits resets to 13; the
// user must write it only while the unit is idle; nothing here enforces it.
module gear_hash_chunker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ghc_pkg::MASK_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ghc_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ghc_pkg::t_out_word            o_out_word
);

    logic [ghc_pkg::MASK_W-1:0] r_mask_bits;
    logic                       r_s1_valid;
    logic [1:0]                 r_s1_opcode;

    logic                       in_accept;
    logic                       core_ready;
    logic [ghc_pkg::WORD_W-1:0] gear_word;
    ghc_pkg::t_stage_ctl        s1_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_s1_valid || core_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_bits <= ghc_pkg::MASK_BITS_RESET;
            r_s1_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mask_bits <= i_cfg_data;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (core_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_opcode <= i_in_word.opcode;
        end
    end

    assign s1_ctl.valid  = r_s1_valid;
    assign s1_ctl.opcode = r_s1_opcode;

    ghc_gear_mem u_gear_mem (
        .i_clk   (i_clk),
        .i_we    (in_accept && (i_in_word.opcode == ghc_pkg::OP_TABLE)),
        .i_waddr (i_in_word.table_index),
        .i_wdata (i_in_word.table_word),
        .i_re    (in_accept),
        .i_raddr (i_in_word.byte_value),
        .o_rdata (gear_word)
    );

    ghc_chunk_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s1_ctl),
        .i_gear_word (gear_word),
        .i_mask_bits (r_mask_bits),
        .o_ready     (core_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
